### design/spim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spim_pkg
// Shared types, codes and reset values of the spi master bit engine.
// ----------------------------------------------------------------------------
package spim_pkg;

   localparam int MAX_WORD_BITS_DEFAULT = 32;
   localparam int CSR_INDEX_BITS        = 3;
   localparam int CSR_DATA_BITS         = 16;

   localparam logic [15:0] HALF_PERIOD_RESET    = 16'd500;
   localparam logic        CLOCK_POLARITY_RESET = 1'b1;
   localparam logic        CLOCK_PHASE_RESET    = 1'b1;
   localparam logic        CS_ACTIVE_LOW_RESET  = 1'b1;
   localparam logic [5:0]  WORD_BITS_RESET      = 6'd8;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_HALF_PERIOD    = 3'd0,
      REG_CLOCK_POLARITY = 3'd1,
      REG_CLOCK_PHASE    = 3'd2,
      REG_CS_ACTIVE_LOW  = 3'd3,
      REG_WORD_BITS      = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      ACT_TICK        = 4'd0,
      ACT_START       = 4'd1,
      ACT_STOP        = 4'd2,
      ACT_TRANSFER    = 4'd3,
      ACT_BIT_READ    = 4'd4,
      ACT_CLK_PULSE   = 4'd5,
      ACT_CLK_HIGH    = 4'd6,
      ACT_CLK_LOW     = 4'd7,
      ACT_MOSI_HIGH   = 4'd8,
      ACT_MOSI_LOW    = 4'd9,
      ACT_SAMPLE_MISO = 4'd10
   } action_type;

   typedef enum logic [1:0] {
      OP_IDLE      = 2'd0,
      OP_TRANSFER  = 2'd1,
      OP_BIT_READ  = 2'd2,
      OP_CLK_PULSE = 2'd3
   } op_kind_type;

   typedef struct packed {
      logic [15:0] half_period;
      logic        clock_polarity;
      logic        clock_phase;
      logic        cs_active_low;
      logic [5:0]  word_bits;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  action;
      logic [31:0] tx_word;
      logic        miso_level;
   } req_type;

   typedef struct packed {
      logic        clk_level;
      logic        mosi_level;
      logic        cs_level;
      logic        busy_res;
      logic [31:0] rx_word;
      logic        rx_valid;
      logic        command_ignored;
   } rsp_type;

endpackage

### design/spim_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spim_csr
// Configuration registers, written through the csr channel.
// ----------------------------------------------------------------------------
module spim_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spim_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [spim_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output spim_pkg::cfg_type                   cfg
);

   spim_pkg::cfg_type cfg_ff;
   spim_pkg::cfg_type cfg_in;
   logic              write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (spim_pkg::reg_index_type'(csr_index))
            spim_pkg::REG_HALF_PERIOD:    cfg_in.half_period    = csr_wdata[15:0];
            spim_pkg::REG_CLOCK_POLARITY: cfg_in.clock_polarity = csr_wdata[0];
            spim_pkg::REG_CLOCK_PHASE:    cfg_in.clock_phase    = csr_wdata[0];
            spim_pkg::REG_CS_ACTIVE_LOW:  cfg_in.cs_active_low  = csr_wdata[0];
            spim_pkg::REG_WORD_BITS:      cfg_in.word_bits      = csr_wdata[5:0];
            default: ;  // writes beyond the register list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period    <= spim_pkg::HALF_PERIOD_RESET;
         cfg_ff.clock_polarity <= spim_pkg::CLOCK_POLARITY_RESET;
         cfg_ff.clock_phase    <= spim_pkg::CLOCK_PHASE_RESET;
         cfg_ff.cs_active_low  <= spim_pkg::CS_ACTIVE_LOW_RESET;
         cfg_ff.word_bits      <= spim_pkg::WORD_BITS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/spim_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spim_engine
// Pin state, shift registers and half period timer; one tick per step.
// ----------------------------------------------------------------------------
module spim_engine #(
   parameter int MAX_WORD_BITS = spim_pkg::MAX_WORD_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  spim_pkg::req_type req,
   input  spim_pkg::cfg_type cfg,
   output spim_pkg::rsp_type res
);

   localparam logic [5:0] WORD_LIMIT = (MAX_WORD_BITS < 32) ? 6'(MAX_WORD_BITS) : 6'd32;

   spim_pkg::op_kind_type op_kind_ff, op_kind_in;
   logic [31:0] tx_shift_ff, tx_shift_in;
   logic [31:0] rx_shift_ff, rx_shift_in;
   logic [5:0]  bits_left_ff, bits_left_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic        half_phase_ff, half_phase_in;
   logic        clk_ff, clk_in;
   logic        mosi_ff, mosi_in;
   logic        cs_ff, cs_in;

   spim_pkg::action_type action;
   logic [15:0] hp;
   logic [16:0] tick_sum;
   logic [15:0] tick_next;
   logic        expire;
   logic [5:0]  n_bits;
   logic [31:0] tx_aligned;

   assign action     = spim_pkg::action_type'(req.action);
   assign hp         = (cfg.half_period == 16'd0) ? 16'd1 : cfg.half_period;
   assign tick_sum   = {1'b0, tick_count_ff} + 17'd1;
   assign tick_next  = tick_sum[15:0];
   assign expire     = tick_next >= hp;
   assign n_bits     = (cfg.word_bits == 6'd0) ? 6'd1 :
                       (cfg.word_bits > WORD_LIMIT) ? WORD_LIMIT : cfg.word_bits;
   // word msb lands in bit 31, bits above the word fall off
   assign tx_aligned = req.tx_word << (6'd32 - n_bits);

   // next operation
   always_comb begin
      op_kind_in = op_kind_ff;
      if (op_kind_ff != spim_pkg::OP_IDLE) begin
         if (expire && !half_phase_ff) begin
            if (op_kind_ff == spim_pkg::OP_CLK_PULSE || bits_left_ff == 6'd0) begin
               op_kind_in = spim_pkg::OP_IDLE;
            end
         end
      end else begin
         case (action)
            spim_pkg::ACT_TRANSFER:  op_kind_in = spim_pkg::OP_TRANSFER;
            spim_pkg::ACT_BIT_READ:  op_kind_in = spim_pkg::OP_BIT_READ;
            spim_pkg::ACT_CLK_PULSE: op_kind_in = spim_pkg::OP_CLK_PULSE;
            default: ;
         endcase
      end
   end

   // pins, shifters and result
   always_comb begin
      tx_shift_in   = tx_shift_ff;
      rx_shift_in   = rx_shift_ff;
      bits_left_in  = bits_left_ff;
      tick_count_in = tick_count_ff;
      half_phase_in = half_phase_ff;
      clk_in        = clk_ff;
      mosi_in       = mosi_ff;
      cs_in         = cs_ff;
      res           = '0;
      if (op_kind_ff != spim_pkg::OP_IDLE) begin
         res.command_ignored = (req.action >= spim_pkg::ACT_START) &&
                               (req.action <= spim_pkg::ACT_SAMPLE_MISO);
         tick_count_in = tick_next;
         if (expire) begin
            tick_count_in = '0;
            if (op_kind_ff == spim_pkg::OP_CLK_PULSE) begin
               if (half_phase_ff) begin
                  clk_in        = cfg.clock_polarity;
                  half_phase_in = 1'b0;
               end
            end else if (half_phase_ff) begin
               // trailing half: toggle and sample
               clk_in        = ~clk_ff;
               rx_shift_in   = {rx_shift_ff[30:0], req.miso_level};
               if (bits_left_ff != 6'd0) begin
                  bits_left_in = bits_left_ff - 6'd1;
               end
               half_phase_in = 1'b0;
            end else begin
               if (!cfg.clock_phase) begin
                  clk_in = ~clk_ff;
               end
               if (bits_left_ff != 6'd0) begin
                  // leading half of the next bit
                  if (cfg.clock_phase) begin
                     clk_in = ~clk_ff;
                  end
                  mosi_in       = tx_shift_ff[31];
                  tx_shift_in   = {tx_shift_ff[30:0], 1'b0};
                  half_phase_in = 1'b1;
               end else begin
                  res.rx_word  = rx_shift_ff;
                  res.rx_valid = 1'b1;
               end
            end
         end
      end else begin
         case (action)
            spim_pkg::ACT_START: cs_in = ~cfg.cs_active_low;
            spim_pkg::ACT_STOP:  cs_in = cfg.cs_active_low;
            spim_pkg::ACT_TRANSFER: begin
               clk_in        = cfg.clock_polarity ^ cfg.clock_phase;
               mosi_in       = tx_aligned[31];
               tx_shift_in   = {tx_aligned[30:0], 1'b0};
               rx_shift_in   = '0;
               bits_left_in  = n_bits;
               tick_count_in = '0;
               half_phase_in = 1'b1;
            end
            spim_pkg::ACT_BIT_READ: begin
               clk_in        = clk_ff ^ cfg.clock_phase;
               mosi_in       = 1'b1;
               tx_shift_in   = {{31{1'b1}}, 1'b0};
               rx_shift_in   = '0;
               bits_left_in  = 6'd1;
               tick_count_in = '0;
               half_phase_in = 1'b1;
            end
            spim_pkg::ACT_CLK_PULSE: begin
               clk_in        = ~cfg.clock_polarity;
               tick_count_in = '0;
               half_phase_in = 1'b1;
            end
            spim_pkg::ACT_CLK_HIGH:  clk_in  = 1'b1;
            spim_pkg::ACT_CLK_LOW:   clk_in  = 1'b0;
            spim_pkg::ACT_MOSI_HIGH: mosi_in = 1'b1;
            spim_pkg::ACT_MOSI_LOW:  mosi_in = 1'b0;
            spim_pkg::ACT_SAMPLE_MISO: begin
               res.rx_word  = {31'd0, req.miso_level};
               res.rx_valid = 1'b1;
            end
            default: ;
         endcase
      end
      res.clk_level  = clk_in;
      res.mosi_level = mosi_in;
      res.cs_level   = cs_in;
      res.busy_res   = op_kind_in != spim_pkg::OP_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_kind_ff    <= spim_pkg::OP_IDLE;
         tx_shift_ff   <= '0;
         rx_shift_ff   <= '0;
         bits_left_ff  <= '0;
         tick_count_ff <= '0;
         half_phase_ff <= 1'b0;
         clk_ff        <= spim_pkg::CLOCK_POLARITY_RESET;
         mosi_ff       <= 1'b0;
         cs_ff         <= spim_pkg::CS_ACTIVE_LOW_RESET;
      end else if (step) begin
         op_kind_ff    <= op_kind_in;
         tx_shift_ff   <= tx_shift_in;
         rx_shift_ff   <= rx_shift_in;
         bits_left_ff  <= bits_left_in;
         tick_count_ff <= tick_count_in;
         half_phase_ff <= half_phase_in;
         clk_ff        <= clk_in;
         mosi_ff       <= mosi_in;
         cs_ff         <= cs_in;
      end
   end

   a_idle_never_flags: assert property (@(posedge clock) disable iff (reset)
      (op_kind_ff == spim_pkg::OP_IDLE) |-> !res.command_ignored)
      else $error("command flagged while idle");

   a_bits_in_range: assert property (@(posedge clock) disable iff (reset)
      bits_left_ff <= WORD_LIMIT)
      else $error("bit count beyond word limit");

   a_rx_only_when_idle_after: assert property (@(posedge clock) disable iff (reset)
      res.rx_valid |-> (op_kind_in == spim_pkg::OP_IDLE))
      else $error("received word reported while still busy");

endmodule

### design/spi_master_bit_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_master_bit_engine_core
// SPI master bit engine for clock modes 0 to 3, driven one tick at a time.
// ----------------------------------------------------------------------------
// Each request transaction is one tick of the bit timer and carries a command
// and the present MISO level; it yields exactly one response transaction with
// the pin levels after the tick, busy, any received word and the dropped
// command flag. Throughput is one transaction per clock cycle while responses
// are taken: the whole tick is one pass of logic from the engine state into
// the response register, so a response appears the cycle after acceptance and
// a new request is taken in the same cycle as the previous response is taken.
// Configuration writes are accepted at any time but are meant for idle
// periods; the engine reads the registers live at each half period.
module spi_master_bit_engine_core #(
   parameter int MAX_WORD_BITS = spim_pkg::MAX_WORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  spim_pkg::req_type                   req_payload,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output spim_pkg::rsp_type                   rsp_payload,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spim_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [spim_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   spim_pkg::cfg_type cfg;
   spim_pkg::rsp_type res;
   spim_pkg::rsp_type rsp_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              step;

   // a request moves whenever the response register is empty or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   spim_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spim_engine #(
      .MAX_WORD_BITS (MAX_WORD_BITS)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_payload),
      .cfg   (cfg),
      .res   (res)
   );

   // response register valid: set by a step, cleared once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // a held response blocks new requests, so no transaction is overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !step)
      else $error("request accepted over a pending response");

endmodule
